// ===== src/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, constants and helpers for the first-free slot store.
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int SLOTS     = 64;
    localparam int BAG_WIDTH = 32;
    localparam int SLOT_W    = 7;                 // slot number, 0..SLOTS
    localparam int IDX_W     = $clog2(SLOTS);     // slot index, slot - 1
    localparam int GRP       = 8;                 // occupancy bits per group
    localparam int GRP_W     = $clog2(GRP);
    localparam int NGRP      = SLOTS / GRP;
    localparam int NGRP_W    = $clog2(NGRP);

    typedef enum logic [1:0] {
        OP_DEP_FIRST = 2'd0,
        OP_DEP_AT    = 2'd1,
        OP_WITHDRAW  = 2'd2,
        OP_QUERY     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_BAD      = 3'd2,
        STS_EMPTY    = 3'd3,
        STS_OCCUPIED = 3'd4
    } t_status;

    typedef struct packed {
        t_op                  operation;
        logic [SLOT_W-1:0]    slot;
        logic [BAG_WIDTH-1:0] bag;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]    result_slot;
        logic [BAG_WIDTH-1:0] result_bag;
        logic                 slot_free;
        logic [SLOT_W-1:0]    free_count;
        t_status              status;
    } t_res;

    // Occupancy update from the sequencer to the occupancy map.
    typedef struct packed {
        logic             we;
        logic             set_val;
        logic [IDX_W-1:0] idx;
    } t_occ_upd;

    // Clamp a slot count register value to 1..SLOTS.
    function automatic logic [SLOT_W-1:0] eff_slots(input logic [SLOT_W-1:0] v);
        logic [SLOT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SLOT_W'(1);
        end else if (v > SLOT_W'(SLOTS)) begin
            r = SLOT_W'(SLOTS);
        end
        return r;
    endfunction

endpackage

// ===== src/fss_payload_ram.sv =====
// ----------------------------------------------------------------------------
// fss_payload_ram
// Single-port-write, registered-read payload memory.
// ----------------------------------------------------------------------------
module fss_payload_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fss_occ_map.sv =====
// ----------------------------------------------------------------------------
// fss_occ_map
// Occupancy flags with a registered per-group first-free summary.
// ----------------------------------------------------------------------------
module fss_occ_map (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clr,
    input  logic                     i_snap,
    input  fss_pkg::t_occ_upd        i_upd,
    input  logic [fss_pkg::IDX_W-1:0] i_idx,
    output logic                     o_occ_bit,
    output logic [fss_pkg::IDX_W-1:0] o_first_idx
);
    import fss_pkg::*;

    logic [SLOTS-1:0] r_occ;
    logic [NGRP-1:0]  r_grp_free;
    logic [GRP_W-1:0] r_grp_pos [NGRP];

    logic [NGRP-1:0]  n_grp_free;
    logic [GRP_W-1:0] n_grp_pos [NGRP];
    logic [NGRP_W-1:0] w_grp_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_occ <= '0;
        end else if (i_upd.we) begin
            r_occ[i_upd.idx] <= i_upd.set_val;
        end
    end

    // Per-group lowest free bit, lowest index wins.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp_free[g] = ~&r_occ[g*GRP +: GRP];
            n_grp_pos[g]  = '0;
            for (int b = GRP - 1; b >= 0; b--) begin
                if (!r_occ[g*GRP + b]) begin
                    n_grp_pos[g] = GRP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap) begin
            r_grp_free <= n_grp_free;
            r_grp_pos  <= n_grp_pos;
        end
    end

    always_comb begin
        w_grp_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_free[g]) begin
                w_grp_sel = NGRP_W'(g);
            end
        end
    end

    assign o_first_idx = {w_grp_sel, r_grp_pos[w_grp_sel]};
    assign o_occ_bit   = r_occ[i_idx];

`ifndef SYNTHESIS
    a_clr_empties : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr |=> (r_occ == '0))
        else $error("occupancy not cleared");

    a_upd_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd.we && !i_clr) |=> (r_occ[$past(i_upd.idx)] == $past(i_upd.set_val)))
        else $error("occupancy update lost");
`endif

endmodule

// ===== src/first_free_slot_store.sv =====
// ----------------------------------------------------------------------------
// first_free_slot_store
// Numbered slot store: deposit first free, deposit at slot, withdraw, query.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_req_valid / o_req_ready / i_req) carries one operation,
//   a slot number (1..slots_in_use) and a payload tag. Result channel
//   (o_res_valid / i_res_ready / o_res) returns exactly one result per
//   request: the slot used, a withdrawn tag, the slot's free state, the
//   free count and a status code.
//   An accepted request is held in the request register while it executes;
//   its result goes to the output register. Requests are taken only in idle,
//   not before the last one commits. Payload is read at accept and written
//   on commit; the lowest free slot comes from a per-group summary registered
//   at accept and a final group select in execute; occupancy is updated there.
//   A new request is taken while a finished result waits in the output
//   register; if the receiver stalls, the next request holds in execute
//   until the output register frees up.
//   Reset: slots_in_use = 64, every slot free, no result pending. Writing
//   slots_in_use (i_cfg_we) empties the store; write only while idle.
//   Payload entries are undefined until deposited, and the read data is only
//   used behind a set occupancy flag.
// ----------------------------------------------------------------------------
module first_free_slot_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  fss_pkg::t_req              i_req,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output fss_pkg::t_res              o_res,
    input  logic                       i_cfg_we,
    input  logic [fss_pkg::SLOT_W-1:0] i_cfg_data
);
    import fss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state            r_state, n_state;
    t_req              r_req;
    t_res              r_res, n_res;
    logic              r_res_valid;
    logic [SLOT_W-1:0] r_slots;
    logic [SLOT_W-1:0] r_count, n_count;

    logic              w_accept;
    logic              w_commit;
    logic [SLOT_W-1:0] w_n;
    logic [SLOT_W-1:0] w_in_m1;
    logic [SLOT_W-1:0] w_req_m1;
    logic [IDX_W-1:0]  w_req_idx;
    logic              w_bad;
    logic              w_occ_bit;
    logic [IDX_W-1:0]  w_first_idx;
    logic [BAG_WIDTH-1:0] w_rdata;
    t_occ_upd          w_upd;
    logic              w_mem_we;
    logic [IDX_W-1:0]  w_mem_waddr;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_commit    = (r_state == S_EXEC) && (!r_res_valid || i_res_ready);

    assign w_n       = eff_slots(r_slots);
    assign w_in_m1   = i_req.slot - SLOT_W'(1);
    assign w_req_m1  = r_req.slot - SLOT_W'(1);
    assign w_req_idx = w_req_m1[IDX_W-1:0];
    assign w_bad     = (r_req.slot == '0) || (r_req.slot > w_n);

    // Payload memory: read at accept, write on commit. The sequencer keeps
    // the read and the write of one request in different cycles.
    fss_payload_ram #(
        .DEPTH (SLOTS),
        .WIDTH (BAG_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (r_req.bag),
        .i_re    (w_accept),
        .i_raddr (w_in_m1[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    fss_occ_map u_occ (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (i_cfg_we),
        .i_snap      (w_accept),
        .i_upd       (w_upd),
        .i_idx       (w_req_idx),
        .o_occ_bit   (w_occ_bit),
        .o_first_idx (w_first_idx)
    );

    // Execute: decide the result and the state update for the held request.
    always_comb begin
        n_res             = '0;
        n_res.status      = STS_OK;
        w_upd             = '0;
        w_mem_we          = 1'b0;
        w_mem_waddr       = w_req_idx;
        n_count           = r_count;

        case (r_req.operation)
            OP_DEP_FIRST: begin
                if (r_count == '0) begin
                    n_res.status = STS_FULL;
                end else begin
                    n_res.result_slot = SLOT_W'(w_first_idx) + SLOT_W'(1);
                    w_upd.we          = 1'b1;
                    w_upd.set_val     = 1'b1;
                    w_upd.idx         = w_first_idx;
                    w_mem_we          = 1'b1;
                    w_mem_waddr       = w_first_idx;
                    n_count           = r_count - SLOT_W'(1);
                end
            end
            OP_DEP_AT: begin
                if (w_bad) begin
                    n_res.status = STS_BAD;
                end else if (w_occ_bit) begin
                    n_res.result_slot = r_req.slot;
                    n_res.status      = STS_OCCUPIED;
                end else begin
                    n_res.result_slot = r_req.slot;
                    w_upd.we          = 1'b1;
                    w_upd.set_val     = 1'b1;
                    w_upd.idx         = w_req_idx;
                    w_mem_we          = 1'b1;
                    n_count           = r_count - SLOT_W'(1);
                end
            end
            OP_WITHDRAW: begin
                if (w_bad) begin
                    n_res.status = STS_BAD;
                end else if (!w_occ_bit) begin
                    n_res.result_slot = r_req.slot;
                    n_res.slot_free   = 1'b1;
                    n_res.status      = STS_EMPTY;
                end else begin
                    n_res.result_slot = r_req.slot;
                    n_res.result_bag  = w_rdata;
                    n_res.slot_free   = 1'b1;
                    w_upd.we          = 1'b1;
                    w_upd.set_val     = 1'b0;
                    w_upd.idx         = w_req_idx;
                    n_count           = r_count + SLOT_W'(1);
                end
            end
            OP_QUERY: begin
                if (w_bad) begin
                    n_res.status = STS_BAD;
                end else begin
                    n_res.result_slot = r_req.slot;
                    n_res.slot_free   = !w_occ_bit;
                end
            end
            default: begin
                n_res.status = STS_BAD;
            end
        endcase

        n_res.free_count = n_count;

        // Drop all side effects until the output register can take the result.
        if (!w_commit) begin
            w_upd    = '0;
            w_mem_we = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_slots     <= SLOT_W'(SLOTS);
            r_count     <= SLOT_W'(SLOTS);
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                // Empty the store under the new slot count.
                r_slots <= i_cfg_data;
                r_count <= eff_slots(i_cfg_data);
            end else if (w_commit) begin
                r_count <= n_count;
            end
        end
    end

    // Hold the request for the execute state and the result on commit; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (w_commit) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_count_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= w_n)
        else $error("free count above slot count");

    a_full_means_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == STS_FULL)) |-> (o_res.free_count == '0))
        else $error("full reported with free slots");

    a_commit_returns : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_state == S_IDLE) && r_res_valid)
        else $error("commit did not publish result");
`endif

endmodule

// ===== tb/fss_result_checker.sv =====
// ----------------------------------------------------------------------------
// fss_result_checker
// Watches both channels of the slot store and keeps its own copy of the
// occupancy, tags and free count. It works out each result from the request
// and compares every returned result field by field, in order.
// ----------------------------------------------------------------------------
module fss_result_checker
    import fss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  t_req              i_req,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  t_res              i_res,
    input  logic              i_cfg_we,
    input  logic [SLOT_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    logic                 held [1:SLOTS];
    logic [BAG_WIDTH-1:0] tag_store [1:SLOTS];
    logic [SLOT_W-1:0]    free_slots;
    logic [SLOT_W-1:0]    slot_limit;
    t_res                 awaited_results [$];

    initial o_fail_count = 0;
    initial o_pending    = 0;

    // Empty the store for a new slot count; 0 counts as one slot, large as SLOTS.
    task automatic empty_store(input logic [SLOT_W-1:0] count);
        if (count == '0) begin
            slot_limit = SLOT_W'(1);
        end else if (count > SLOT_W'(SLOTS)) begin
            slot_limit = SLOT_W'(SLOTS);
        end else begin
            slot_limit = count;
        end
        for (int k = 1; k <= SLOTS; k++) begin
            held[k] = 1'b0;
        end
        free_slots = slot_limit;
    endtask

    function automatic t_res apply_request(input t_req r);
        t_res o;
        int   pick;
        o        = '0;
        o.status = STS_OK;
        if (r.operation == OP_DEP_FIRST) begin
            pick = 0;
            for (int k = SLOTS; k >= 1; k--) begin
                if (k <= int'(slot_limit) && !held[k]) begin
                    pick = k;
                end
            end
            if (pick == 0) begin
                o.status = STS_FULL;
            end else begin
                held[pick]      = 1'b1;
                tag_store[pick] = r.bag;
                free_slots      = free_slots - SLOT_W'(1);
                o.result_slot   = SLOT_W'(pick);
            end
        end else if (r.slot == '0 || r.slot > slot_limit) begin
            o.status = STS_BAD;
        end else begin
            o.result_slot = r.slot;
            case (r.operation)
                OP_DEP_AT: begin
                    if (held[r.slot]) begin
                        o.status = STS_OCCUPIED;
                    end else begin
                        held[r.slot]      = 1'b1;
                        tag_store[r.slot] = r.bag;
                        free_slots        = free_slots - SLOT_W'(1);
                    end
                end
                OP_WITHDRAW: begin
                    o.slot_free = 1'b1;
                    if (!held[r.slot]) begin
                        o.status = STS_EMPTY;
                    end else begin
                        o.result_bag = tag_store[r.slot];
                        held[r.slot] = 1'b0;
                        free_slots   = free_slots + SLOT_W'(1);
                    end
                end
                default: begin
                    o.slot_free = !held[r.slot];
                end
            endcase
        end
        o.free_count = free_slots;
        return o;
    endfunction

    task automatic compare_field(input string field, input logic [BAG_WIDTH-1:0] want,
                                 input logic [BAG_WIDTH-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            awaited_results.delete();
            empty_store(SLOT_W'(SLOTS));
        end else begin
            // Check the result before taking a new request in the same cycle.
            if (i_res_valid && i_res_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result_slot: expected no result, got 0x%0h", i_res.result_slot);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("result_slot", BAG_WIDTH'(want.result_slot),
                                  BAG_WIDTH'(i_res.result_slot));
                    compare_field("result_bag", want.result_bag, i_res.result_bag);
                    compare_field("slot_free", BAG_WIDTH'(want.slot_free),
                                  BAG_WIDTH'(i_res.slot_free));
                    compare_field("free_count", BAG_WIDTH'(want.free_count),
                                  BAG_WIDTH'(i_res.free_count));
                    compare_field("status", BAG_WIDTH'(want.status),
                                  BAG_WIDTH'(i_res.status));
                end
            end
            if (i_cfg_we) begin
                empty_store(i_cfg_data);
            end
            if (i_req_valid && i_req_ready) begin
                awaited_results.push_back(apply_request(i_req));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the first-free slot store with a directed opening and random
// phases over several slot counts, with random idle bursts on both channels.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import fss_pkg::*;

    // Generous cycle budget for ~1450 requests, plus
    // the idle pauses around each slot-count write.
    localparam int CYCLE_LIMIT = 500000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    t_req              req       = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    t_res              res;
    logic              cfg_we    = 1'b0;
    logic [SLOT_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int cycles        = 0;
    int req_gap_pct   = 0;   // chance of an idle burst before a request
    int res_stall_pct = 0;   // chance of a stall burst on the result side
    int stall_left    = 0;

    always #5 clk = ~clk;

    first_free_slot_store i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    fss_result_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res        (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Hard stop in case a result never shows up or the handshake hangs.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: at random, hold ready low in stall bursts.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            res_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (res_stall_pct != 0 && $urandom_range(0, 99) < res_stall_pct) begin
            res_ready <= 1'b0;
            stall_left = $urandom_range(1, 18) - 1;
        end else begin
            res_ready <= 1'b1;
        end
    end

    // Present one request and hold it until the block takes it. Valid stays
    // high from one request to the next unless an idle burst falls between.
    task automatic send_request(input t_op op, input logic [SLOT_W-1:0] slot,
                                input logic [BAG_WIDTH-1:0] bag);
        @(negedge clk);
        if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_valid     <= 1'b1;
        req.operation <= op;
        req.slot      <= slot;
        req.bag       <= bag;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // Drop valid and wait until every outstanding result has come back,
    // then let the block settle.
    task automatic drain;
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the slot count; only done with the block idle.
    task automatic set_slots(input logic [SLOT_W-1:0] count);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= count;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One random phase. Most slot numbers are in range so the store fills
    // and drains for real; the rest are zero or past the limit. The deposit
    // share steers how full the store runs.
    task automatic run_phase(input logic [SLOT_W-1:0] count, input int items,
                             input int deposit_pct, input int idle_pct);
        int                lim;
        int                roll;
        t_op               op;
        logic [SLOT_W-1:0] slot;
        set_slots(count);
        lim           = (count == '0) ? 1 : (count > SLOT_W'(SLOTS)) ? SLOTS : int'(count);
        req_gap_pct   = idle_pct;
        res_stall_pct = idle_pct;
        repeat (items) begin
            roll = $urandom_range(0, 99);
            if (roll < deposit_pct) begin
                op = ($urandom_range(0, 1) == 0) ? OP_DEP_FIRST : OP_DEP_AT;
            end else begin
                op = ($urandom_range(0, 9) < 7) ? OP_WITHDRAW : OP_QUERY;
            end
            if ($urandom_range(0, 99) < 88) begin
                slot = SLOT_W'($urandom_range(1, lim));
            end else if ($urandom_range(0, 2) == 0) begin
                slot = '0;
            end else begin
                slot = SLOT_W'($urandom_range(lim + 1, 127));
            end
            send_request(op, slot, $urandom);
        end
    endtask

    initial begin
        // Reset once, synchronous.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening at the reset slot count of 64.
        req_gap_pct   = 20;
        res_stall_pct = 20;
        send_request(OP_QUERY, 7'd1, 32'h0000_0000);
        send_request(OP_WITHDRAW, 7'd5, 32'hFFFF_FFFF);   // withdraw from free slot
        send_request(OP_DEP_FIRST, 7'd0, 32'hFFFF_FFFF);
        send_request(OP_DEP_AT, 7'd64, 32'h0000_0000);
        send_request(OP_DEP_AT, 7'd64, 32'h1234_5678);    // deposit onto occupied
        send_request(OP_DEP_AT, 7'd0, 32'hDEAD_BEEF);     // slot zero is bad
        send_request(OP_QUERY, 7'd65, 32'h0000_0000);     // past the limit
        send_request(OP_WITHDRAW, 7'd127, 32'h0000_0000); // top of the field
        send_request(OP_QUERY, 7'd64, 32'h0000_0000);
        send_request(OP_DEP_FIRST, 7'd127, 32'h5A5A_5A5A); // slot ignored here
        send_request(OP_WITHDRAW, 7'd64, 32'h0000_0000);
        send_request(OP_WITHDRAW, 7'd1, 32'h0000_0000);
        send_request(OP_DEP_FIRST, 7'd0, 32'hA5A5_A5A5);  // lowest free is 1 again

        // Single slot: fill it, then hit the full case.
        set_slots(7'd1);
        send_request(OP_DEP_FIRST, 7'd0, 32'h89AB_CDEF);
        send_request(OP_DEP_FIRST, 7'd0, 32'h0000_0001);
        send_request(OP_DEP_AT, 7'd2, 32'h0000_0002);
        send_request(OP_QUERY, 7'd1, 32'h0000_0000);
        send_request(OP_WITHDRAW, 7'd1, 32'h0000_0000);

        // A count of zero acts as one slot.
        set_slots(7'd0);
        send_request(OP_DEP_AT, 7'd1, 32'h7FFF_FFFF);
        send_request(OP_DEP_FIRST, 7'd0, 32'h8000_0000);

        // All ones clamps to the full 64 slots.
        set_slots(7'd127);
        send_request(OP_DEP_AT, 7'd64, 32'hCAFE_F00D);
        send_request(OP_QUERY, 7'd65, 32'h0000_0000);
        send_request(OP_WITHDRAW, 7'd64, 32'h0000_0000);

        // Random phases; one without idling in the middle, none at the end.
        run_phase(7'd2, 200, 55, 25);
        run_phase(7'd8, 200, 55, 30);
        run_phase(7'd64, 200, 80, 20);
        run_phase(7'd65, 200, 50, 0);
        run_phase(7'd3, 200, 55, 35);
        run_phase(SLOT_W'($urandom_range(4, 63)), 200, 60, 25);
        run_phase(7'd64, 200, 50, 0);

        drain();
        repeat (6) @(posedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
